@@ sv/dotted_address_parser_core_assert.svh @@
// Assertion macros shared by the dotted address parser RTL.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef DOTTED_ADDRESS_PARSER_CORE_ASSERT_SVH
`define DOTTED_ADDRESS_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, off during reset
`define DAP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dap: same-cycle check failed");

// Next-cycle implication, off during reset
`define DAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dap: next-cycle check failed");

`endif

@@ sv/dap_pkg.sv @@
// Package for the dotted address parser: phase codes, character codes and
// the structs passed between the decoder, the parse step and the top level.
`timescale 1ns / 1ps

package dap_pkg;

  localparam int CharW  = 8;
  localparam int FieldW = 8;
  localparam int AddrW  = 48;
  localparam int IdxW   = 3;

  // Parse phases
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_FIELD = 2'd1;
  localparam logic [1:0] PH_TAIL  = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  // Address modes
  localparam logic MODE_IPV4  = 1'b0;
  localparam logic MODE_ETHER = 1'b1;

  // Index of the last field in each mode
  localparam logic [IdxW-1:0] LAST_IPV4  = 3'd3;
  localparam logic [IdxW-1:0] LAST_ETHER = 3'd5;

  // Character codes
  localparam logic [CharW-1:0] CH_ZERO = 8'h30;
  localparam logic [CharW-1:0] CH_NINE = 8'h39;
  localparam logic [CharW-1:0] CH_UA   = 8'h41;
  localparam logic [CharW-1:0] CH_UF   = 8'h46;
  localparam logic [CharW-1:0] CH_DOT  = 8'h2E;
  localparam logic [CharW-1:0] CH_CR   = 8'h0D;
  localparam logic [CharW-1:0] CH_NUL  = 8'h00;

  // Character class from the decoder
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_dot;
    logic       is_term;
  } char_class_t;

  // One result from the parse step
  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [AddrW-1:0] value;
  } step_result_t;

endpackage

@@ sv/dap_char_decode.sv @@
// Character decoder for the dotted address parser: digit, dot, terminator.
// Depends on dap_pkg.
`timescale 1ns / 1ps

module dap_char_decode
  import dap_pkg::*;
(
  input  logic [CharW-1:0] char_code,
  input  logic             address_mode,
  output char_class_t      cls
);

  logic dec_hit;
  logic hex_hit;

  // Classify the character for the current radix
  always_comb begin
    dec_hit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    hex_hit = (address_mode == MODE_ETHER) && (char_code >= CH_UA) && (char_code <= CH_UF);
    cls.is_digit = dec_hit || hex_hit;
    if (dec_hit) begin
      cls.digit = 4'(char_code - CH_ZERO);
    end else if (hex_hit) begin
      cls.digit = 4'(char_code - CH_UA + 8'd10);
    end else begin
      cls.digit = 4'd0;
    end
    cls.is_dot  = (char_code == CH_DOT);
    cls.is_term = (char_code == CH_NUL) || (char_code == CH_CR);
  end

endmodule

@@ sv/dap_parse_step.sv @@
// Parse state and per-character step logic of the dotted address parser.
// Depends on dap_pkg; fed by dap_char_decode.
`timescale 1ns / 1ps

module dap_parse_step
  import dap_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         address_mode,
  input  char_class_t  cls,
  output step_result_t res
);

  logic [1:0]        parse_phase, parse_phase_next;
  logic [IdxW-1:0]   field_index, field_index_next;
  logic [FieldW-1:0] field_acc, field_acc_next;
  logic [AddrW-1:0]  addr_store, addr_store_next;

  logic [IdxW-1:0]   last_idx;
  logic [FieldW-1:0] acc_mac;
  logic [AddrW-1:0]  store_shifted;
  logic              do_fail;
  logic              do_ok;
  logic [AddrW-1:0]  ok_src;

  // Next state and result for the character at hand
  always_comb begin
    last_idx = (address_mode == MODE_ETHER) ? LAST_ETHER : LAST_IPV4;
    if (address_mode == MODE_ETHER) begin
      acc_mac = FieldW'({field_acc[3:0], 4'b0000}) + FieldW'(cls.digit);
    end else begin
      acc_mac = FieldW'({field_acc[4:0], 3'b000}) + FieldW'({field_acc[6:0], 1'b0})
              + FieldW'(cls.digit);
    end
    store_shifted = {addr_store[AddrW-FieldW-1:0], field_acc};

    parse_phase_next = parse_phase;
    field_index_next = field_index;
    field_acc_next   = field_acc;
    addr_store_next  = addr_store;
    do_fail = 1'b0;
    do_ok   = 1'b0;
    ok_src  = addr_store;

    case (parse_phase)
      PH_SKIP: begin
        if (cls.is_term) begin
          parse_phase_next = PH_START;
          field_index_next = '0;
          field_acc_next   = '0;
          addr_store_next  = '0;
        end
      end
      PH_START: begin
        if (!cls.is_digit) begin
          do_fail = 1'b1;
        end else begin
          field_acc_next   = FieldW'(cls.digit);
          parse_phase_next = PH_FIELD;
        end
      end
      PH_FIELD: begin
        if (cls.is_digit) begin
          field_acc_next = acc_mac;
        end else begin
          addr_store_next = store_shifted;
          field_acc_next  = '0;
          ok_src          = store_shifted;
          if (field_index < last_idx) begin
            if (!cls.is_dot) begin
              do_fail = 1'b1;
            end else begin
              field_index_next = field_index + 3'd1;
              parse_phase_next = PH_START;
            end
          end else if (cls.is_dot) begin
            parse_phase_next = PH_TAIL;
          end else if (cls.is_term) begin
            do_ok = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
      end
      default: begin
        if (cls.is_term) begin
          do_ok = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
    endcase

    // A failure skips to the next terminator unless this one ends it;
    // a success always restarts
    if (do_fail && !cls.is_term) begin
      parse_phase_next = PH_SKIP;
    end else if (do_fail || do_ok) begin
      parse_phase_next = PH_START;
      field_index_next = '0;
      field_acc_next   = '0;
      addr_store_next  = '0;
    end

    res.valid = do_fail || do_ok;
    res.ok    = do_ok;
    if (!do_ok) begin
      res.value = '0;
    end else if (address_mode == MODE_IPV4) begin
      res.value = {16'h0000, ok_src[31:0]};
    end else begin
      res.value = ok_src;
    end
  end

  // Advance the parse state on each processed character
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_START;
      field_index <= '0;
      field_acc   <= '0;
      addr_store  <= '0;
    end else if (step) begin
      parse_phase <= parse_phase_next;
      field_index <= field_index_next;
      field_acc   <= field_acc_next;
      addr_store  <= addr_store_next;
    end
  end

endmodule

@@ sv/dotted_address_parser_core.sv @@
// Dotted address parser: one character per transfer, IPv4 or Ethernet.
// Path: the input register feeds the parse step, whose result loads the result
// register, which drives m_tvalid.
// Throughput: one character per cycle, set by the single registered parse step;
// a result held by a low m_tready stalls the input register behind it.
// Reset (rst, synchronous) empties both registers, clears the parse state and
// selects IPv4 mode.
`timescale 1ns / 1ps

`include "dotted_address_parser_core_assert.svh"

module dotted_address_parser_core
  import dap_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Configuration: address_mode
  input  logic             cfg_we,
  input  logic [0:0]       cfg_wdata,   // [0] address_mode
  // Input characters
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [CharW-1:0] s_tdata,     // [7:0] char_code
  // Results
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [AddrW-1:0] m_tdata,     // [47:0] address_value
  output logic [0:0]       m_tuser      // [0] parse_ok
);

  logic             address_mode;
  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             advance;
  char_class_t      cls;
  step_result_t     res;

  // Process the held character once the result register can take a result
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      address_mode <= MODE_IPV4;
    end else if (cfg_we) begin
      address_mode <= cfg_wdata[0];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
  end

  dap_char_decode u_decode (
    .char_code    (in_char),
    .address_mode (address_mode),
    .cls          (cls)
  );

  dap_parse_step u_step (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .address_mode (address_mode),
    .cls          (cls),
    .res          (res)
  );

  // Result register: load on a produced result, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata    <= res.value;
      m_tuser[0] <= res.ok;
    end
  end

  // Checks
  `DAP_ASSERT_IMP(a_fail_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
  `DAP_ASSERT_NEXT(a_hold_char, in_valid && m_tvalid && !m_tready, in_valid)
  `DAP_ASSERT_IMP(a_ready_empty, !in_valid, s_tready)

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for dotted_address_parser_core: directed and random
// character streams, checked against an in-bench parser. Depends on dap_pkg.
`timescale 1ns / 1ps

module tb_top;
  import dap_pkg::*;

  localparam int LATENCY = 1;
  localparam int SETTLE = LATENCY + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CHARS = 1700;
  localparam logic [CharW-1:0] CH_LA = 8'h61;  // lowercase 'a'

  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] value;
  } parse_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [CharW-1:0] s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [AddrW-1:0] m_tdata;
  logic [0:0]       m_tuser;

  // In-bench copy of the parser state and mode register
  logic             mdl_mode;
  logic [1:0]       mdl_phase;
  logic [IdxW-1:0]  mdl_field;
  logic [FieldW-1:0] mdl_acc;
  logic [AddrW-1:0] mdl_store;

  parse_result_t pending_parses[$];
  int            mismatches = 0;
  int            sent_chars = 0;
  int            stall_left = 0;
  int            ready_gap;
  bit            steady = 1'b0;
  parse_result_t got_parse;
  parse_result_t want_parse;

  dotted_address_parser_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // [7:0] char_code
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // [47:0] address_value
    .m_tuser   (m_tuser)      // [0] parse_ok
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void restart_string();
    mdl_phase = PH_START;
    mdl_field = '0;
    mdl_acc = '0;
    mdl_store = '0;
  endfunction

  function automatic bit is_terminator(logic [CharW-1:0] c);
    return c == CH_NUL || c == CH_CR;
  endfunction

  function automatic void reject_char(logic [CharW-1:0] c);
    pending_parses.push_back('{ok: 1'b0, value: '0});
    if (is_terminator(c)) restart_string();
    else mdl_phase = PH_SKIP;
  endfunction

  function automatic void accept_address();
    logic [AddrW-1:0] v;
    v = mdl_store;
    if (mdl_mode == MODE_IPV4) v[AddrW-1:32] = '0;
    pending_parses.push_back('{ok: 1'b1, value: v});
    restart_string();
  endfunction

  // Advance the parser by one character and queue any result it yields
  function automatic void parse_char(logic [CharW-1:0] c);
    int digit;
    int radix;
    logic [IdxW-1:0] last;
    last = (mdl_mode == MODE_ETHER) ? LAST_ETHER : LAST_IPV4;
    radix = (mdl_mode == MODE_ETHER) ? 16 : 10;
    digit = -1;
    if (c >= CH_ZERO && c <= CH_NINE) digit = int'(c) - int'(CH_ZERO);
    else if (mdl_mode == MODE_ETHER && c >= CH_UA && c <= CH_UF)
      digit = int'(c) - int'(CH_UA) + 10;

    case (mdl_phase)
      PH_SKIP: begin
        if (is_terminator(c)) restart_string();
      end
      PH_START: begin
        if (digit < 0) reject_char(c);
        else begin
          mdl_acc = digit[FieldW-1:0];
          mdl_phase = PH_FIELD;
        end
      end
      PH_FIELD: begin
        if (digit >= 0) begin
          mdl_acc = FieldW'(int'(mdl_acc) * radix + digit);
        end else begin
          mdl_store = {mdl_store[AddrW-FieldW-1:0], mdl_acc};
          mdl_acc = '0;
          if (mdl_field < last) begin
            if (c != CH_DOT) reject_char(c);
            else begin
              mdl_field = mdl_field + 1'b1;
              mdl_phase = PH_START;
            end
          end else if (c == CH_DOT) mdl_phase = PH_TAIL;
          else if (is_terminator(c)) accept_address();
          else reject_char(c);
        end
      end
      default: begin
        if (is_terminator(c)) accept_address();
        else reject_char(c);
      end
    endcase
  endfunction

  // Send one character; returns at the edge where the transfer happened
  task automatic send_char(input logic [CharW-1:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    parse_char(c);
    sent_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Hold the sender until every result is in and the pipeline has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    mdl_mode = mode;
    cfg_we <= 1'b0;
  endtask

  // Build one dotted address, optionally damaged, and send it
  task automatic send_address(input bit ether, input bit corrupt, input bit terminate);
    logic [CharW-1:0] text[$];
    int nfields, len, f, i, v, k;
    nfields = ether ? 6 : 4;
    for (f = 0; f < nfields; f++) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, ether ? 2 : 3)
                                        : $urandom_range(1, 5);
      for (i = 0; i < len; i++) begin
        v = ether ? $urandom_range(0, 15) : $urandom_range(0, 9);
        text.push_back(CharW'(v < 10 ? int'(CH_ZERO) + v : int'(CH_UA) + v - 10));
      end
      if (f < nfields - 1) text.push_back(CH_DOT);
    end
    if ($urandom_range(0, 3) == 0) text.push_back(CH_DOT);
    if (terminate) text.push_back($urandom_range(0, 1) ? CH_NUL : CH_CR);
    if (corrupt) begin
      k = $urandom_range(0, text.size() - 1);
      case ($urandom_range(0, 3))
        0: text[k] = CharW'($urandom_range(0, 255));
        1: text.delete(k);
        2: text.insert(k, CharW'($urandom_range(0, 255)));
        default: text[k] = CharW'(int'(CH_LA) + $urandom_range(0, 5));
      endcase
    end
    foreach (text[j]) send_char(text[j]);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) send_char(CharW'($urandom_range(0, 255)));
    send_char($urandom_range(0, 1) ? CH_NUL : CH_CR);
  endtask

  // IPv4 from reset: empty string, extreme fields with tail dot, skip, errors
  task automatic test_ipv4_directed();
    send_char(CH_NUL);
    send_text("255.0.9.1.");
    send_char(CH_CR);
    send_text("1a");
    send_char(CH_NUL);
    send_text("7");
    send_char(CH_CR);
    send_char(8'hFF);
    send_char(CH_CR);
    send_text("300.1.2.3");
    send_char(CH_NUL);
    drain();
  endtask

  // Ethernet: full hex range, then a lowercase digit
  task automatic test_ether_directed();
    write_mode(MODE_ETHER);
    send_text("FF.0.A9.00.1.F");
    send_char(CH_NUL);
    send_text("f");
    send_char(CH_CR);
    drain();
  endtask

  // Change mode in the middle of a string, both directions
  task automatic test_mode_switch();
    send_text("1.2.3.4");
    drain();
    write_mode(MODE_IPV4);
    send_char(CH_NUL);
    send_text("1.2");
    drain();
    write_mode(MODE_ETHER);
    send_text(".3.4.5.6");
    send_char(CH_CR);
    drain();
  endtask

  // Mostly well-formed addresses with random content, some damaged or noise
  task automatic test_random_streams();
    int pass_no, goal, r;
    for (pass_no = 0; pass_no < 7; pass_no++) begin
      write_mode(pass_no == 0 ? MODE_IPV4 :
                 (pass_no == 1 ? MODE_ETHER : 1'($urandom_range(0, 1))));
      steady = (pass_no == 3);
      goal = sent_chars + RANDOM_CHARS / 7;
      while (sent_chars < goal) begin
        r = $urandom_range(0, 99);
        if (r < 70) send_address(mdl_mode == MODE_ETHER, 1'b0, 1'b1);
        else if (r < 80) send_address(mdl_mode != MODE_ETHER, 1'b0, 1'b1);
        else if (r < 90) send_address(1'($urandom_range(0, 1)), 1'b1, 1'b1);
        else send_noise();
      end
      // leave a string open across the mode write now and then
      if ($urandom_range(0, 1)) send_address(1'($urandom_range(0, 1)), 1'b0, 1'b0);
      steady = 1'b0;
      drain();
    end
  endtask

  // Check each result transfer against the oldest queued parse
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_parse = '{ok: m_tuser[0], value: m_tdata};
      if (pending_parses.size() == 0) begin
        $error("unexpected result: parse_ok %0d address_value %h", got_parse.ok, got_parse.value);
        mismatches++;
      end else begin
        want_parse = pending_parses.pop_front();
        if (got_parse.ok !== want_parse.ok) begin
          $error("parse_ok: expected %0d, got %0d", want_parse.ok, got_parse.ok);
          mismatches++;
        end
        if (got_parse.value !== want_parse.value) begin
          $error("address_value: expected %h, got %h", want_parse.value, got_parse.value);
          mismatches++;
        end
      end
    end
    // stall the result side at random
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      ready_gap = pick_gap();
      m_tready <= (ready_gap == 0);
      stall_left <= (ready_gap > 0) ? ready_gap - 1 : 0;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL dotted_address_parser_core");
    $finish;
  end

  initial begin
    mdl_mode = MODE_IPV4;
    restart_string();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ipv4_directed();
    test_ether_directed();
    test_mode_switch();
    test_random_streams();

    drain();
    if (mismatches == 0 && pending_parses.size() == 0) begin
      $display("PASS dotted_address_parser_core");
    end else begin
      $display("FAIL dotted_address_parser_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dap_pkg.sv
sv/dap_char_decode.sv
sv/dap_parse_step.sv
sv/dotted_address_parser_core.sv
tb/sv/tb_top.sv
